// ===== design/dcmrc_pkg.sv =====
// Shared types and constants for the drive command multiplexer with radio override.
package dcmrc_pkg;

    // Field widths fixed by the request formats.
    localparam int WIDTH_PULSE = 16;
    localparam int WIDTH_CODE  = 8;
    localparam int WIDTH_GAIN  = 9;
    localparam int WIDTH_ACT   = 3;
    localparam int WIDTH_CIDX  = 4;

    // Half-width of the steering centre band, exclusive on both sides.
    localparam logic [WIDTH_PULSE-1:0] CENTER_BAND = 16'd50;

    // Action codes carried in each result.
    localparam logic [WIDTH_ACT-1:0] ACT_HOLD     = 3'd0;
    localparam logic [WIDTH_ACT-1:0] ACT_RADIO    = 3'd1;
    localparam logic [WIDTH_ACT-1:0] ACT_BRAKE    = 3'd2;
    localparam logic [WIDTH_ACT-1:0] ACT_DRIVE    = 3'd3;
    localparam logic [WIDTH_ACT-1:0] ACT_FAILSAFE = 3'd4;

    // Configuration register indexes.
    localparam logic [WIDTH_CIDX-1:0] REG_THR_ON      = 4'd0;
    localparam logic [WIDTH_CIDX-1:0] REG_THR_BRAKE   = 4'd1;
    localparam logic [WIDTH_CIDX-1:0] REG_STEER_ACT   = 4'd2;
    localparam logic [WIDTH_CIDX-1:0] REG_STEER_DEACT = 4'd3;
    localparam logic [WIDTH_CIDX-1:0] REG_STOP_WIDTH  = 4'd4;
    localparam logic [WIDTH_CIDX-1:0] REG_CENTER      = 4'd5;
    localparam logic [WIDTH_CIDX-1:0] REG_FWD_GAIN    = 4'd6;
    localparam logic [WIDTH_CIDX-1:0] REG_BWD_GAIN    = 4'd7;

    // Configuration values after reset.
    localparam logic [WIDTH_PULSE-1:0] RST_THR_ON      = 16'd1000;
    localparam logic [WIDTH_PULSE-1:0] RST_THR_BRAKE   = 16'd1300;
    localparam logic [WIDTH_PULSE-1:0] RST_STEER_ACT   = 16'd1800;
    localparam logic [WIDTH_PULSE-1:0] RST_STEER_DEACT = 16'd1200;
    localparam logic [WIDTH_PULSE-1:0] RST_STOP_WIDTH  = 16'd1500;
    localparam logic [WIDTH_PULSE-1:0] RST_CENTER      = 16'd1500;
    localparam logic [WIDTH_GAIN-1:0]  RST_FWD_GAIN    = 9'd51;
    localparam logic [WIDTH_GAIN-1:0]  RST_BWD_GAIN    = 9'd205;

    // One input request per control tick.
    typedef struct packed {
        logic [WIDTH_PULSE-1:0] rc_throttle_width;
        logic [WIDTH_PULSE-1:0] rc_steering_width;
        logic                   command_valid;
        logic [WIDTH_CODE-1:0]  command_speed;
        logic [WIDTH_CODE-1:0]  command_angle;
    } t_cmd;

    // One result request per control tick.
    typedef struct packed {
        logic [WIDTH_ACT-1:0]   action;
        logic [WIDTH_CODE-1:0]  esc_speed_code;
        logic [WIDTH_CODE-1:0]  servo_angle_code;
        logic [WIDTH_PULSE-1:0] esc_forward_width;
        logic [WIDTH_PULSE-1:0] steer_forward_width;
        logic                   led_level;
        logic                   radio_mode;
    } t_res;

    // One configuration write.
    typedef struct packed {
        logic [WIDTH_CIDX-1:0]  index;
        logic [WIDTH_PULSE-1:0] value;
    } t_cfg;

endpackage

// ===== design/dcmrc_if.sv =====
// Valid/ready channel interfaces for tick, result and configuration requests.
interface dcmrc_cmd_if;
    logic              valid;
    logic              ready;
    dcmrc_pkg::t_cmd   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface dcmrc_res_if;
    logic              valid;
    logic              ready;
    dcmrc_pkg::t_res   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface dcmrc_cfg_if;
    logic              valid;
    logic              ready;
    dcmrc_pkg::t_cfg   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== design/drive_command_mux_with_rc_override.sv =====
// Top level: drive command multiplexer with radio override gesture and failsafe.
//
// Usage: each control tick is one request on i_cmd, carrying the measured radio
// throttle and steering pulse widths and an optional autonomous command. Every
// tick request yields exactly one result request on o_res: the chosen action,
// the ESC/servo codes or the forwarded pulse widths, the LED level and the mode.
// Configuration registers are written over i_cfg (index, value) while the block
// is idle; the user must keep to this, the block does not enforce it. Writes are
// always accepted and indexes past the list are ignored. A request accepted
// waits in the input register until the result register is free or is being
// taken; then the decision logic and the one 16x9 attenuation multiplier load
// the result register. Throughput is one tick per cycle while the receiver takes
// results; the input register and the result register form a two-stage pipeline,
// so a new tick is taken while a finished result still waits. When the receiver
// stalls, the result holds and the input register fills, after which i_cmd.ready
// drops until the result is taken. Reset (synchronous, active low) empties both
// stages, loads the configuration defaults and returns the mode, gesture
// counters, LED, pending command and silence counter to their idle values.
module drive_command_mux_with_rc_override #(
    parameter int SILENCE_LIMIT       = 50,
    parameter int GESTURE_TICKS       = 20,
    parameter int CENTER_WINDOW_TICKS = 100,
    parameter int STOP_SPEED_CODE     = 0,
    parameter int CENTER_ANGLE_CODE   = 90
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dcmrc_cmd_if.sink          i_cmd,
    dcmrc_res_if.source        o_res,
    dcmrc_cfg_if.sink          i_cfg
);

    localparam logic [7:0] L_SILENCE = 8'(SILENCE_LIMIT);
    localparam logic [7:0] L_GESTURE = 8'(GESTURE_TICKS);
    localparam logic [7:0] L_WINDOW  = 8'(CENTER_WINDOW_TICKS);
    localparam logic [7:0] L_STOP    = 8'(STOP_SPEED_CODE);
    localparam logic [7:0] L_CENTRE  = 8'(CENTER_ANGLE_CODE);

    // Configuration registers.
    logic [15:0] r_thr_on, r_thr_brake, r_steer_act, r_steer_deact;
    logic [15:0] r_stop_width, r_center;
    logic [8:0]  r_fwd_gain, r_bwd_gain;

    // Pipeline registers.
    logic            r_in_valid;
    dcmrc_pkg::t_cmd r_in;
    logic            r_out_valid;
    dcmrc_pkg::t_res r_out;
    dcmrc_pkg::t_res n_out;

    // Tick state.
    logic       r_pending, n_pending;
    logic [7:0] r_held_speed, n_held_speed;
    logic [7:0] r_held_angle, n_held_angle;
    logic [7:0] r_silent, n_silent;
    logic       r_override, n_override;
    logic [7:0] r_above, n_above;
    logic [7:0] r_below, n_below;
    logic [7:0] r_window, n_window;
    logic       r_blink, n_blink;
    logic       r_led, n_led;

    logic w_move;
    logic w_cfg_wr;

    // Decision datapath signals.
    logic [15:0] w_thr, w_steer;
    logic        w_thr_on, w_radio, w_in_band;
    logic        w_above_stop, w_below_stop;
    logic [15:0] w_diff;
    logic [8:0]  w_gain;
    logic [24:0] w_prod;
    logic [16:0] w_scaled;
    logic [17:0] w_up_sum;
    logic [15:0] w_esc_width;

    assign w_move   = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_cfg_wr = i_cfg.valid && i_cfg.ready;

    assign i_cmd.ready = !r_in_valid || w_move;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_on      <= dcmrc_pkg::RST_THR_ON;
            r_thr_brake   <= dcmrc_pkg::RST_THR_BRAKE;
            r_steer_act   <= dcmrc_pkg::RST_STEER_ACT;
            r_steer_deact <= dcmrc_pkg::RST_STEER_DEACT;
            r_stop_width  <= dcmrc_pkg::RST_STOP_WIDTH;
            r_center      <= dcmrc_pkg::RST_CENTER;
            r_fwd_gain    <= dcmrc_pkg::RST_FWD_GAIN;
            r_bwd_gain    <= dcmrc_pkg::RST_BWD_GAIN;
        end else if (w_cfg_wr) begin
            unique case (i_cfg.data.index)
                dcmrc_pkg::REG_THR_ON:      r_thr_on      <= i_cfg.data.value;
                dcmrc_pkg::REG_THR_BRAKE:   r_thr_brake   <= i_cfg.data.value;
                dcmrc_pkg::REG_STEER_ACT:   r_steer_act   <= i_cfg.data.value;
                dcmrc_pkg::REG_STEER_DEACT: r_steer_deact <= i_cfg.data.value;
                dcmrc_pkg::REG_STOP_WIDTH:  r_stop_width  <= i_cfg.data.value;
                dcmrc_pkg::REG_CENTER:      r_center      <= i_cfg.data.value;
                dcmrc_pkg::REG_FWD_GAIN:    r_fwd_gain    <= i_cfg.data.value[8:0];
                dcmrc_pkg::REG_BWD_GAIN:    r_bwd_gain    <= i_cfg.data.value[8:0];
                default: ;
            endcase
        end
    end

    // Input register: holds one tick request until it can move on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.data;
        end
    end

    // Throttle attenuation about the stop width, one shared multiplier.
    assign w_thr        = r_in.rc_throttle_width;
    assign w_steer      = r_in.rc_steering_width;
    assign w_above_stop = w_thr > r_stop_width;
    assign w_below_stop = w_thr < r_stop_width;
    assign w_diff       = w_above_stop ? (w_thr - r_stop_width) : (r_stop_width - w_thr);
    assign w_gain       = w_above_stop ? r_fwd_gain : r_bwd_gain;
    assign w_prod       = {9'd0, w_diff} * {16'd0, w_gain};
    assign w_scaled     = w_prod[24:8];
    assign w_up_sum     = {2'd0, r_stop_width} + {1'b0, w_scaled};

    always_comb begin
        if (w_above_stop) begin
            w_esc_width = (w_up_sum > 18'h0FFFF) ? 16'hFFFF : w_up_sum[15:0];
        end else if (w_below_stop) begin
            w_esc_width = (w_scaled > {1'b0, r_stop_width}) ? 16'd0
                        : (r_stop_width - w_scaled[15:0]);
        end else begin
            w_esc_width = r_stop_width;
        end
    end

    // Steering strictly inside the centre band, computed without wrap.
    assign w_in_band = (({1'b0, w_steer} + {1'b0, dcmrc_pkg::CENTER_BAND}) > {1'b0, r_center})
                    && ({1'b0, w_steer} < ({1'b0, r_center} + {1'b0, dcmrc_pkg::CENTER_BAND}));

    assign w_thr_on = w_thr > r_thr_on;

    // Per-tick decision: command latch, gesture machine, then one action.
    always_comb begin
        n_pending    = r_pending;
        n_held_speed = r_held_speed;
        n_held_angle = r_held_angle;
        n_silent     = r_silent;
        n_override   = r_override;
        n_above      = r_above;
        n_below      = r_below;
        n_window     = r_window;
        n_blink      = r_blink;
        n_led        = r_led;
        n_out        = '0;

        // A new command is latched first so that it can drive this very tick.
        if (r_in.command_valid) begin
            n_held_speed = r_in.command_speed;
            n_held_angle = r_in.command_angle;
            n_pending    = 1'b1;
        end

        // Gesture machine runs only while the radio is active.
        if (w_thr_on) begin
            n_led = r_override;
            if (r_window == 8'd0) begin
                if (!r_override && (w_steer > r_steer_act)) begin
                    if (r_above < L_GESTURE) begin
                        n_above = r_above + 8'd1;
                    end else begin
                        n_window = L_WINDOW;
                    end
                end else if (r_override && (w_steer < r_steer_deact)) begin
                    if (r_below < L_GESTURE) begin
                        n_below = r_below + 8'd1;
                    end else begin
                        n_window = L_WINDOW;
                    end
                end
            end else begin
                n_above = 8'd0;
                n_below = 8'd0;
                n_led   = !r_blink;
                n_blink = !r_blink;
                if (w_in_band) begin
                    n_override = !r_override;
                    n_window   = 8'd0;
                end else begin
                    n_window = r_window - 8'd1;
                end
            end
            if (w_steer >= r_steer_deact) begin
                n_below = 8'd0;
            end
            if (w_steer <= r_steer_act) begin
                n_above = 8'd0;
            end
        end

        w_radio = w_thr_on && n_override;

        priority if (w_radio) begin
            n_out.action              = dcmrc_pkg::ACT_RADIO;
            n_out.esc_forward_width   = w_esc_width;
            n_out.steer_forward_width = w_steer;
        end else if ((w_thr >= r_thr_on) && (w_thr <= r_thr_brake)) begin
            n_out.action         = dcmrc_pkg::ACT_BRAKE;
            n_out.esc_speed_code = L_STOP;
        end else if (n_pending) begin
            n_out.action           = dcmrc_pkg::ACT_DRIVE;
            n_out.esc_speed_code   = n_held_speed;
            n_out.servo_angle_code = n_held_angle;
            n_pending              = 1'b0;
            n_silent               = 8'd0;
        end else if (r_silent > L_SILENCE) begin
            n_out.action           = dcmrc_pkg::ACT_FAILSAFE;
            n_out.esc_speed_code   = L_STOP;
            n_out.servo_angle_code = L_CENTRE;
            n_held_speed           = L_STOP;
            n_held_angle           = L_CENTRE;
        end else begin
            n_out.action = dcmrc_pkg::ACT_HOLD;
            n_silent     = r_silent + 8'd1;
        end

        n_out.led_level  = n_led;
        n_out.radio_mode = n_override;
    end

    // Tick state advances when a request moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 1'b0;
            r_held_speed <= L_STOP;
            r_held_angle <= L_CENTRE;
            r_silent     <= 8'd0;
            r_override   <= 1'b0;
            r_above      <= 8'd0;
            r_below      <= 8'd0;
            r_window     <= 8'd0;
            r_blink      <= 1'b0;
            r_led        <= 1'b0;
        end else if (w_move) begin
            r_pending    <= n_pending;
            r_held_speed <= n_held_speed;
            r_held_angle <= n_held_angle;
            r_silent     <= n_silent;
            r_override   <= n_override;
            r_above      <= n_above;
            r_below      <= n_below;
            r_window     <= n_window;
            r_blink      <= n_blink;
            r_led        <= n_led;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= n_out;
        end
    end

    // A radio forward result is only ever given with the mode flag set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.data.action == dcmrc_pkg::ACT_RADIO)) |-> o_res.data.radio_mode)
        else $error("radio forward result without radio mode");

    // The centre window never opens wider than its configured length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window <= L_WINDOW)
        else $error("centre window beyond its length");

    // Gesture counters stop at the hold length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_above <= L_GESTURE) && (r_below <= L_GESTURE))
        else $error("gesture counter beyond hold length");

    // The silence counter stops one past its limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_silent <= (L_SILENCE + 8'd1))
        else $error("silence counter beyond limit");

    // A request moving out of the input register is offered as a result next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> o_res.valid)
        else $error("moved request not offered as a result");

endmodule
